// ----- rtl/vcc_pkg.sv -----
// Package: shared types, register map and reset values for the velocity command conditioner.
package vcc_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned FILT_W  = 32;
    localparam int unsigned ALPHA_W = 16;
    localparam int unsigned DZ_W    = 15;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_DEAD_ZONE    = 3'd0,
        REG_MAX_X        = 3'd1,
        REG_MIN_X        = 3'd2,
        REG_MAX_Y        = 3'd3,
        REG_MIN_Y        = 3'd4,
        REG_MAX_YAW      = 3'd5,
        REG_MIN_YAW      = 3'd6,
        REG_ALPHA_PLANAR = 3'd7
    } t_reg_idx;

    typedef logic signed [DATA_W-1:0] t_q4_12;
    typedef logic signed [FILT_W-1:0] t_q4_28;

    typedef struct packed {
        t_q4_12 hi;
        t_q4_12 lo;
    } t_limits;

    localparam logic [DZ_W-1:0]    DEAD_ZONE_RST    = 15'd205;
    localparam t_q4_12             MAX_X_RST        = 16'sd4096;
    localparam t_q4_12             MIN_X_RST        = -16'sd2048;
    localparam t_q4_12             MAX_Y_RST        = 16'sd1638;
    localparam t_q4_12             MIN_Y_RST        = -16'sd1638;
    localparam t_q4_12             MAX_YAW_RST      = 16'sd2458;
    localparam t_q4_12             MIN_YAW_RST      = -16'sd2458;
    localparam logic [ALPHA_W-1:0] ALPHA_PLANAR_RST = 16'd1966;

endpackage

// ----- rtl/vcc_axis.sv -----
// One axis: dead zone and clamp of a command word, and one low-pass filter update.
module vcc_axis
    import vcc_pkg::*;
(
    input  t_q4_12               i_vel,
    input  logic [DATA_W-1:0]    i_thresh,
    input  t_limits              i_lim,
    input  logic [ALPHA_W-1:0]   i_alpha,
    input  t_q4_12               i_held,
    input  t_q4_28               i_filt,
    output t_q4_12               o_held,
    output t_q4_28               o_filt
);

    logic signed [DATA_W:0]            vel_ext;
    logic        [DATA_W:0]            mag;
    t_q4_12                            dz_val;
    t_q4_12                            hi_val;
    logic signed [DATA_W+ALPHA_W:0]    gain;
    logic        [ALPHA_W:0]           keep_w;
    logic signed [FILT_W+ALPHA_W+1:0]  prod;
    logic signed [FILT_W+1:0]          keep;
    logic signed [FILT_W+1:0]          sum;

    assign vel_ext = {i_vel[DATA_W-1], i_vel};
    assign mag     = vel_ext[DATA_W] ? (DATA_W+1)'(0) - vel_ext : vel_ext;
    assign dz_val  = (mag < {1'b0, i_thresh}) ? '0 : i_vel;
    assign hi_val  = (dz_val > i_lim.hi) ? i_lim.hi : dz_val;
    assign o_held  = (hi_val < i_lim.lo) ? i_lim.lo : hi_val;

    assign gain   = i_held * $signed({1'b0, i_alpha});
    assign keep_w = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, i_alpha};
    assign prod   = i_filt * $signed({1'b0, keep_w});
    assign keep   = prod[FILT_W+ALPHA_W+1:ALPHA_W];
    assign sum    = keep + {gain[DATA_W+ALPHA_W], gain};
    assign o_filt = sum[FILT_W-1:0];

endmodule

// ----- rtl/velocity_command_conditioner.sv -----
// Velocity command conditioner: dead zone, clamp and low-pass filter on x, y and yaw rate.
//
// Each input word carries an action bit: 0 loads a new command sample (dead zone, then clamp,
// then hold; no output word), 1 steps the three filters and emits one output word with the
// filtered x, y and yaw rate in Q4.12 (top 16 bits of the Q4.28 state). A word passes through
// an input register and one pass of per-axis logic into the output register, so the block
// takes one word per cycle; it stalls only when the output register holds an unaccepted
// word and the next word is a tick. The cycle is set by the 32 x 17 filter multiply and the
// add behind it. The x and y filters share the alpha_planar register; the yaw filter uses the
// ALPHA_YAW parameter (Q0.16). Registers sit at byte address 4*index on the APB port; the
// user must write them only while the block is idle, which the block itself does not enforce.
module velocity_command_conditioner
    import vcc_pkg::*;
#(
    parameter logic [ALPHA_W-1:0] ALPHA_YAW = 16'd3277
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  t_q4_12              i_vel_x,
    input  t_q4_12              i_vel_y,
    input  t_q4_12              i_yaw_rate,
    output logic                o_valid,
    input  logic                i_ready,
    output t_q4_12              o_out_x,
    output t_q4_12              o_out_y,
    output t_q4_12              o_out_yaw,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [DZ_W-1:0]    r_dead_zone;
    t_limits            r_lim_x;
    t_limits            r_lim_y;
    t_limits            r_lim_yaw;
    logic [ALPHA_W-1:0] r_alpha_planar;

    logic               r_s1_valid;
    logic               r_s1_action;
    t_q4_12             r_s1_x;
    t_q4_12             r_s1_y;
    t_q4_12             r_s1_yaw;

    t_q4_12             r_held_x, r_held_y, r_held_yaw;
    t_q4_28             r_filt_x, r_filt_y, r_filt_yaw;
    t_q4_12             n_held_x, n_held_y, n_held_yaw;
    t_q4_28             n_filt_x, n_filt_y, n_filt_yaw;

    logic               r_out_valid;
    logic               n_out_valid;
    t_q4_12             r_out_x, r_out_y, r_out_yaw;

    logic               out_free;
    logic               s1_fire;
    logic               sample_fire;
    logic               tick_fire;
    logic               in_fire;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic [DATA_W-1:0]  thresh_xy;
    logic [DATA_W-1:0]  thresh_yaw;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone    <= DEAD_ZONE_RST;
            r_lim_x        <= '{hi: MAX_X_RST, lo: MIN_X_RST};
            r_lim_y        <= '{hi: MAX_Y_RST, lo: MIN_Y_RST};
            r_lim_yaw      <= '{hi: MAX_YAW_RST, lo: MIN_YAW_RST};
            r_alpha_planar <= ALPHA_PLANAR_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DEAD_ZONE:    r_dead_zone    <= pwdata[DZ_W-1:0];
                REG_MAX_X:        r_lim_x.hi     <= pwdata[DATA_W-1:0];
                REG_MIN_X:        r_lim_x.lo     <= pwdata[DATA_W-1:0];
                REG_MAX_Y:        r_lim_y.hi     <= pwdata[DATA_W-1:0];
                REG_MIN_Y:        r_lim_y.lo     <= pwdata[DATA_W-1:0];
                REG_MAX_YAW:      r_lim_yaw.hi   <= pwdata[DATA_W-1:0];
                REG_MIN_YAW:      r_lim_yaw.lo   <= pwdata[DATA_W-1:0];
                REG_ALPHA_PLANAR: r_alpha_planar <= pwdata[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DEAD_ZONE:    prdata = PDATA_W'(r_dead_zone);
            REG_MAX_X:        prdata = PDATA_W'(unsigned'(r_lim_x.hi));
            REG_MIN_X:        prdata = PDATA_W'(unsigned'(r_lim_x.lo));
            REG_MAX_Y:        prdata = PDATA_W'(unsigned'(r_lim_y.hi));
            REG_MIN_Y:        prdata = PDATA_W'(unsigned'(r_lim_y.lo));
            REG_MAX_YAW:      prdata = PDATA_W'(unsigned'(r_lim_yaw.hi));
            REG_MIN_YAW:      prdata = PDATA_W'(unsigned'(r_lim_yaw.lo));
            REG_ALPHA_PLANAR: prdata = PDATA_W'(r_alpha_planar);
            default:          prdata = '0;
        endcase
    end

    // flow control
    assign out_free    = !r_out_valid || i_ready;
    assign s1_fire     = r_s1_valid && (!r_s1_action || out_free);
    assign sample_fire = s1_fire && !r_s1_action;
    assign tick_fire   = s1_fire && r_s1_action;
    assign o_ready     = !r_s1_valid || s1_fire;
    assign in_fire     = i_valid && o_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_action <= i_action;
            r_s1_x      <= i_vel_x;
            r_s1_y      <= i_vel_y;
            r_s1_yaw    <= i_yaw_rate;
        end
    end

    // per-axis logic
    assign thresh_xy  = {1'b0, r_dead_zone};
    assign thresh_yaw = {r_dead_zone, 1'b0};

    vcc_axis u_axis_x (
        .i_vel    (r_s1_x),
        .i_thresh (thresh_xy),
        .i_lim    (r_lim_x),
        .i_alpha  (r_alpha_planar),
        .i_held   (r_held_x),
        .i_filt   (r_filt_x),
        .o_held   (n_held_x),
        .o_filt   (n_filt_x)
    );

    vcc_axis u_axis_y (
        .i_vel    (r_s1_y),
        .i_thresh (thresh_xy),
        .i_lim    (r_lim_y),
        .i_alpha  (r_alpha_planar),
        .i_held   (r_held_y),
        .i_filt   (r_filt_y),
        .o_held   (n_held_y),
        .o_filt   (n_filt_y)
    );

    vcc_axis u_axis_yaw (
        .i_vel    (r_s1_yaw),
        .i_thresh (thresh_yaw),
        .i_lim    (r_lim_yaw),
        .i_alpha  (ALPHA_YAW),
        .i_held   (r_held_yaw),
        .i_filt   (r_filt_yaw),
        .o_held   (n_held_yaw),
        .o_filt   (n_filt_yaw)
    );

    // held samples and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x   <= '0;
            r_held_y   <= '0;
            r_held_yaw <= '0;
            r_filt_x   <= '0;
            r_filt_y   <= '0;
            r_filt_yaw <= '0;
        end else begin
            if (sample_fire) begin
                r_held_x   <= n_held_x;
                r_held_y   <= n_held_y;
                r_held_yaw <= n_held_yaw;
            end
            if (tick_fire) begin
                r_filt_x   <= n_filt_x;
                r_filt_y   <= n_filt_y;
                r_filt_yaw <= n_filt_yaw;
            end
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (tick_fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_fire) begin
            r_out_x   <= n_filt_x[FILT_W-1:FILT_W-DATA_W];
            r_out_y   <= n_filt_y[FILT_W-1:FILT_W-DATA_W];
            r_out_yaw <= n_filt_yaw[FILT_W-1:FILT_W-DATA_W];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_out_x   = r_out_x;
    assign o_out_y   = r_out_y;
    assign o_out_yaw = r_out_yaw;

`ifndef SYNTH
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_action))
        else $error("output word without a tick");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_ready)
        else $error("empty input stage refuses a word");

    a_filt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_fire |=> $stable(r_filt_x) && $stable(r_filt_y) && $stable(r_filt_yaw))
        else $error("filter state moved without a tick");

    a_held_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sample_fire |=> $stable(r_held_x) && $stable(r_held_y) && $stable(r_held_yaw))
        else $error("held sample moved without a sample");
`endif

endmodule
